// ===== hw/rtl/drg_pkg.sv =====
package drg_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 30;
    localparam int CFG_IDX_W = 3;
    localparam int VIDX_W  = 3;

    localparam logic [COORD_W-1:0] CORNER_MARGIN = 32'd100;
    localparam logic [COORD_W-1:0] CENTER_MARGIN = 32'd50;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_RADIUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECOR_STYLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECOR_PLACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECOR_EXTENT = 3'd4;

    localparam logic [1:0] STYLE_CHAMFER = 2'd1;
    localparam logic [1:0] STYLE_NOTCH   = 2'd2;

    localparam logic [1:0] PLACE_0 = 2'd0;
    localparam logic [1:0] PLACE_1 = 2'd1;
    localparam logic [1:0] PLACE_2 = 2'd2;
    localparam logic [1:0] PLACE_3 = 2'd3;

    typedef enum logic [1:0] {
        SH_PLAIN,
        SH_ROUND,
        SH_CHAMFER,
        SH_NOTCH
    } shape_t;

    typedef enum logic [1:0] {
        B_LO,
        B_HI,
        B_MID
    } base_t;

    typedef enum logic [2:0] {
        O_ZERO,
        O_PR,
        O_MR,
        O_PD,
        O_MD,
        O_PH,
        O_MH
    } off_t;

    typedef struct packed {
        base_t xb;
        off_t  xo;
        base_t yb;
        off_t  yo;
    } spec_t;

    typedef struct packed {
        logic             center_mode;
        logic [RAD_W-1:0] round_radius;
        logic [1:0]       decor_style;
        logic [1:0]       decor_place;
        logic [RAD_W-1:0] decor_extent;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        shape_t             shape;
        logic [1:0]         place;
    } desc_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               arc;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic               last;
    } vertex_t;

    function automatic spec_t mk(base_t xb, off_t xo, base_t yb, off_t yo);
        spec_t s;
        s.xb = xb;
        s.xo = xo;
        s.yb = yb;
        s.yo = yo;
        return s;
    endfunction

    function automatic logic [VIDX_W-1:0] last_idx(shape_t shape);
        logic [VIDX_W-1:0] n;
        case (shape)
            SH_ROUND:   n = 3'd7;
            SH_CHAMFER: n = 3'd4;
            SH_NOTCH:   n = 3'd6;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic spec_t spec_for(shape_t shape, logic [1:0] place,
                                       logic [VIDX_W-1:0] k);
        spec_t s;
        s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
        case (shape)
            SH_ROUND:
            begin
                case (k)
                    3'd0:    s = mk(B_LO, O_PR, B_LO, O_ZERO);
                    3'd1:    s = mk(B_LO, O_ZERO, B_LO, O_PR);
                    3'd2:    s = mk(B_LO, O_ZERO, B_HI, O_MR);
                    3'd3:    s = mk(B_LO, O_PR, B_HI, O_ZERO);
                    3'd4:    s = mk(B_HI, O_MR, B_HI, O_ZERO);
                    3'd5:    s = mk(B_HI, O_ZERO, B_HI, O_MR);
                    3'd6:    s = mk(B_HI, O_ZERO, B_LO, O_PR);
                    default: s = mk(B_HI, O_MR, B_LO, O_ZERO);
                endcase
            end
            SH_CHAMFER:
            begin
                case (place)
                    PLACE_0:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_MD);
                            3'd2:    s = mk(B_LO, O_PD, B_HI, O_ZERO);
                            3'd3:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                    PLACE_1:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd2:    s = mk(B_HI, O_MD, B_HI, O_ZERO);
                            3'd3:    s = mk(B_HI, O_ZERO, B_HI, O_MD);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                    PLACE_2:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd2:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            3'd3:    s = mk(B_HI, O_ZERO, B_LO, O_PD);
                            default: s = mk(B_HI, O_MD, B_LO, O_ZERO);
                        endcase
                    end
                    default:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_PD, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_LO, O_PD);
                            3'd2:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd3:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                endcase
            end
            SH_NOTCH:
            begin
                case (place)
                    PLACE_0:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd2:    s = mk(B_MID, O_MH, B_MID, O_ZERO);
                            3'd3:    s = mk(B_MID, O_ZERO, B_MID, O_MH);
                            3'd4:    s = mk(B_MID, O_PH, B_MID, O_ZERO);
                            3'd5:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                    PLACE_1:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd2:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            3'd3:    s = mk(B_MID, O_ZERO, B_MID, O_PH);
                            3'd4:    s = mk(B_MID, O_MH, B_MID, O_ZERO);
                            3'd5:    s = mk(B_MID, O_ZERO, B_MID, O_MH);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                    PLACE_2:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd2:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            3'd3:    s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                            3'd4:    s = mk(B_MID, O_PH, B_MID, O_ZERO);
                            3'd5:    s = mk(B_MID, O_ZERO, B_MID, O_PH);
                            default: s = mk(B_MID, O_MH, B_MID, O_ZERO);
                        endcase
                    end
                    default:
                    begin
                        case (k)
                            3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                            3'd1:    s = mk(B_MID, O_ZERO, B_MID, O_MH);
                            3'd2:    s = mk(B_MID, O_PH, B_MID, O_ZERO);
                            3'd3:    s = mk(B_MID, O_ZERO, B_MID, O_PH);
                            3'd4:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                            3'd5:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                            default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                        endcase
                    end
                endcase
            end
            default:
            begin
                case (k)
                    3'd0:    s = mk(B_LO, O_ZERO, B_LO, O_ZERO);
                    3'd1:    s = mk(B_LO, O_ZERO, B_HI, O_ZERO);
                    3'd2:    s = mk(B_HI, O_ZERO, B_HI, O_ZERO);
                    default: s = mk(B_HI, O_ZERO, B_LO, O_ZERO);
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/drg_front.sv =====
module drg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  drg_pkg::cfg_t                 cfg,
    input  logic                          push,
    output logic                          full,
    input  logic [drg_pkg::COORD_W-1:0]   first_x,
    input  logic [drg_pkg::COORD_W-1:0]   first_y,
    input  logic [drg_pkg::COORD_W-1:0]   second_x,
    input  logic [drg_pkg::COORD_W-1:0]   second_y,
    output logic                          q_push,
    input  logic                          q_full,
    output drg_pkg::desc_t                q_data
);

    localparam int W = drg_pkg::COORD_W;

    function automatic logic slt(logic [W-1:0] a, logic [W-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [W-1:0] smin(logic [W-1:0] a, logic [W-1:0] b);
        return slt(a, b) ? a : b;
    endfunction

    function automatic logic [W-1:0] smax(logic [W-1:0] a, logic [W-1:0] b);
        return slt(a, b) ? b : a;
    endfunction

    function automatic logic [W-1:0] sabs(logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [W-1:0] halve(logic [W-1:0] s);
        logic [W-1:0] t;
        t = s + {{(W-1){1'b0}}, s[W-1]};
        return {t[W-1], t[W-1:1]};
    endfunction

    logic         en;
    logic [W-1:0] radius;
    logic [W-1:0] ms;
    logic [W-1:0] lim;

    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg;

    logic [W-1:0] s1_ax_reg, s1_ay_reg, s1_px_reg, s1_py_reg, s1_qx_reg, s1_qy_reg;
    logic [W-1:0] s1_ax_next, s1_ay_next, s1_px_next, s1_py_next, s1_qx_next, s1_qy_next;
    logic [W-1:0] s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic [W-1:0] s2_bx_next, s2_by_next;
    logic [W-1:0] s3_x0_reg, s3_y0_reg, s3_x1_reg, s3_y1_reg;
    logic [W-1:0] s3_x0_next, s3_y0_next, s3_x1_next, s3_y1_next;
    logic [W-1:0] s4_x0_reg, s4_y0_reg, s4_x1_reg, s4_y1_reg, s4_sx_reg, s4_sy_reg;
    logic [W-1:0] s4_sx_next, s4_sy_next;
    drg_pkg::desc_t s5_reg;
    drg_pkg::desc_t s5_next;

    assign en     = !s5_v_reg || !q_full;
    assign full   = !en;
    assign q_push = s5_v_reg && !q_full;
    assign q_data = s5_reg;

    assign radius = {{(W-drg_pkg::RAD_W){1'b0}}, cfg.round_radius};
    assign ms     = {radius[W-2:0], 1'b0} + drg_pkg::CORNER_MARGIN;
    assign lim    = radius + drg_pkg::CENTER_MARGIN;

    always_comb
    begin
        if (cfg.center_mode)
        begin
            s1_ax_next = first_x;
            s1_ay_next = first_y;
            s1_px_next = second_x - first_x;
            s1_py_next = second_y - first_y;
            s1_qx_next = lim;
            s1_qy_next = lim;
        end
        else
        begin
            s1_ax_next = smin(first_x, second_x);
            s1_ay_next = smin(first_y, second_y);
            s1_px_next = smax(first_x, second_x);
            s1_py_next = smax(first_y, second_y);
            s1_qx_next = smin(first_x, second_x) + ms;
            s1_qy_next = smin(first_y, second_y) + ms;
        end
    end

    always_comb
    begin
        if (cfg.center_mode)
        begin
            s2_bx_next = smax(sabs(s1_px_reg), s1_qx_reg);
            s2_by_next = smax(sabs(s1_py_reg), s1_qy_reg);
        end
        else
        begin
            s2_bx_next = smax(s1_px_reg, s1_qx_reg);
            s2_by_next = smax(s1_py_reg, s1_qy_reg);
        end
    end

    always_comb
    begin
        if (cfg.center_mode)
        begin
            s3_x0_next = s2_ax_reg - s2_bx_reg;
            s3_y0_next = s2_ay_reg - s2_by_reg;
            s3_x1_next = s2_ax_reg + s2_bx_reg;
            s3_y1_next = s2_ay_reg + s2_by_reg;
        end
        else
        begin
            s3_x0_next = s2_ax_reg;
            s3_y0_next = s2_ay_reg;
            s3_x1_next = s2_bx_reg;
            s3_y1_next = s2_by_reg;
        end
    end

    always_comb
    begin
        case (cfg.decor_place)
            drg_pkg::PLACE_0:
            begin
                s4_sx_next = s3_x0_reg + s3_x1_reg;
                s4_sy_next = s3_y1_reg + s3_y1_reg;
            end
            drg_pkg::PLACE_1:
            begin
                s4_sx_next = s3_x1_reg + s3_x1_reg;
                s4_sy_next = s3_y0_reg + s3_y1_reg;
            end
            drg_pkg::PLACE_2:
            begin
                s4_sx_next = s3_x1_reg + s3_x0_reg;
                s4_sy_next = s3_y0_reg + s3_y0_reg;
            end
            default:
            begin
                s4_sx_next = s3_x0_reg + s3_x0_reg;
                s4_sy_next = s3_y1_reg + s3_y0_reg;
            end
        endcase
    end

    always_comb
    begin
        s5_next.x0    = s4_x0_reg;
        s5_next.y0    = s4_y0_reg;
        s5_next.x1    = s4_x1_reg;
        s5_next.y1    = s4_y1_reg;
        s5_next.cx    = halve(s4_sx_reg);
        s5_next.cy    = halve(s4_sy_reg);
        s5_next.place = cfg.decor_place;
        if (cfg.round_radius != '0)
            s5_next.shape = drg_pkg::SH_ROUND;
        else if (cfg.decor_style == drg_pkg::STYLE_CHAMFER)
            s5_next.shape = drg_pkg::SH_CHAMFER;
        else if (cfg.decor_style == drg_pkg::STYLE_NOTCH)
            s5_next.shape = drg_pkg::SH_NOTCH;
        else
            s5_next.shape = drg_pkg::SH_PLAIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= push;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ax_reg <= s1_ax_next;
            s1_ay_reg <= s1_ay_next;
            s1_px_reg <= s1_px_next;
            s1_py_reg <= s1_py_next;
            s1_qx_reg <= s1_qx_next;
            s1_qy_reg <= s1_qy_next;
            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
            s2_bx_reg <= s2_bx_next;
            s2_by_reg <= s2_by_next;
            s3_x0_reg <= s3_x0_next;
            s3_y0_reg <= s3_y0_next;
            s3_x1_reg <= s3_x1_next;
            s3_y1_reg <= s3_y1_next;
            s4_x0_reg <= s3_x0_reg;
            s4_y0_reg <= s3_y0_reg;
            s4_x1_reg <= s3_x1_reg;
            s4_y1_reg <= s3_y1_reg;
            s4_sx_reg <= s4_sx_next;
            s4_sy_reg <= s4_sy_next;
            s5_reg    <= s5_next;
        end
    end

endmodule

// ===== hw/rtl/drg_queue.sv =====
module drg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_push,
    output logic           q_full,
    input  drg_pkg::desc_t q_wdata,
    input  logic           q_pop,
    output logic           q_valid,
    output drg_pkg::desc_t q_rdata
);

    drg_pkg::desc_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign q_full  = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_rdata = mem[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wdata;
    end

endmodule

// ===== hw/rtl/drg_back.sv =====
module drg_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  drg_pkg::cfg_t               cfg,
    input  logic                        q_valid,
    input  drg_pkg::desc_t              q_rdata,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output drg_pkg::vertex_t            vout
);

    localparam int W = drg_pkg::COORD_W;

    function automatic logic [W-1:0] place_coord(drg_pkg::base_t b, drg_pkg::off_t o,
                                                 logic [W-1:0] lo, logic [W-1:0] hi,
                                                 logic [W-1:0] mid, logic [W-1:0] r,
                                                 logic [W-1:0] d, logic [W-1:0] h);
        logic [W-1:0] base;
        logic [W-1:0] mag;
        logic         sub;
        case (b)
            drg_pkg::B_HI:  base = hi;
            drg_pkg::B_MID: base = mid;
            default:        base = lo;
        endcase
        case (o)
            drg_pkg::O_PR: begin mag = r; sub = 1'b0; end
            drg_pkg::O_MR: begin mag = r; sub = 1'b1; end
            drg_pkg::O_PD: begin mag = d; sub = 1'b0; end
            drg_pkg::O_MD: begin mag = d; sub = 1'b1; end
            drg_pkg::O_PH: begin mag = h; sub = 1'b0; end
            drg_pkg::O_MH: begin mag = h; sub = 1'b1; end
            default:       begin mag = '0; sub = 1'b0; end
        endcase
        return sub ? base - mag : base + mag;
    endfunction

    drg_pkg::desc_t              cur_reg;
    logic                        cur_v_reg;
    logic [drg_pkg::VIDX_W-1:0]  k_reg;
    drg_pkg::vertex_t            ob_mem [2];
    logic                        ob_wr_reg;
    logic                        ob_rd_reg;
    logic [1:0]                  ob_cnt_reg;
    logic [1:0]                  ob_cnt_next;

    logic [W-1:0]     r;
    logic [W-1:0]     d;
    logic [W-1:0]     h;
    drg_pkg::spec_t   spec;
    drg_pkg::vertex_t vtx;
    logic             emit;
    logic             done;
    logic             out_fire;

    assign r = {{(W-drg_pkg::RAD_W){1'b0}}, cfg.round_radius};
    assign d = {{(W-drg_pkg::RAD_W){1'b0}}, cfg.decor_extent};
    assign h = {1'b0, d[W-1:1]};

    assign spec     = drg_pkg::spec_for(cur_reg.shape, cur_reg.place, k_reg);
    assign emit     = cur_v_reg && ob_cnt_reg != 2'd2;
    assign done     = emit && k_reg == drg_pkg::last_idx(cur_reg.shape);
    assign q_pop    = q_valid && (!cur_v_reg || done);
    assign out_fire = pop && ob_cnt_reg != 2'd0;
    assign empty    = ob_cnt_reg == 2'd0;
    assign vout     = ob_mem[ob_rd_reg];

    always_comb
    begin
        vtx.x    = place_coord(spec.xb, spec.xo, cur_reg.x0, cur_reg.x1, cur_reg.cx, r, d, h);
        vtx.y    = place_coord(spec.yb, spec.yo, cur_reg.y0, cur_reg.y1, cur_reg.cy, r, d, h);
        vtx.arc  = cur_reg.shape == drg_pkg::SH_ROUND && !k_reg[0];
        vtx.last = k_reg == drg_pkg::last_idx(cur_reg.shape);
        vtx.cx   = '0;
        vtx.cy   = '0;
        if (vtx.arc)
        begin
            vtx.cx = k_reg[2] ? cur_reg.x1 - r : cur_reg.x0 + r;
            vtx.cy = (k_reg[2] ^ k_reg[1]) ? cur_reg.y1 - r : cur_reg.y0 + r;
        end
    end

    always_comb
    begin
        ob_cnt_next = ob_cnt_reg;
        if (emit && !out_fire)
            ob_cnt_next = ob_cnt_reg + 2'd1;
        else if (out_fire && !emit)
            ob_cnt_next = ob_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg  <= 1'b0;
            k_reg      <= '0;
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            ob_cnt_reg <= ob_cnt_next;
            if (emit)
                ob_wr_reg <= !ob_wr_reg;
            if (out_fire)
                ob_rd_reg <= !ob_rd_reg;
            if (q_pop)
            begin
                cur_v_reg <= 1'b1;
                k_reg     <= '0;
            end
            else if (done)
            begin
                cur_v_reg <= 1'b0;
                k_reg     <= '0;
            end
            else if (emit)
                k_reg <= k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_rdata;
        if (emit)
            ob_mem[ob_wr_reg] <= vtx;
    end

endmodule

// ===== hw/rtl/decorated_rectangle_outline_generator.sv =====
// Channel   Handshake              Payload
// input     push / full            first_x, first_y, second_x, second_y
// result    empty / pop            vertex_x, vertex_y, is_arc, center_x, center_y, last_vertex
// config    cfg_we                 cfg_index, cfg_data
//
// The front pipeline takes one item per cycle while not full and computes the outline box.
// The back sequencer emits one vertex per cycle while the result buffer has room: 4, 5, 7 or 8
// vertices per item by shape, so that vertex loop sets the sustained rate.
// Reset clears config, valid flags, queues and sequencer state; data registers are not reset.
// A full result buffer stalls the sequencer, then the two-entry queue, then the front.
module decorated_rectangle_outline_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [drg_pkg::COORD_W-1:0]  first_x,
    input  logic signed [drg_pkg::COORD_W-1:0]  first_y,
    input  logic signed [drg_pkg::COORD_W-1:0]  second_x,
    input  logic signed [drg_pkg::COORD_W-1:0]  second_y,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [drg_pkg::COORD_W-1:0]  vertex_x,
    output logic signed [drg_pkg::COORD_W-1:0]  vertex_y,
    output logic                                is_arc,
    output logic signed [drg_pkg::COORD_W-1:0]  center_x,
    output logic signed [drg_pkg::COORD_W-1:0]  center_y,
    output logic                                last_vertex,
    input  logic                                cfg_we,
    input  logic [drg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [drg_pkg::RAD_W-1:0]           cfg_data
);

    drg_pkg::cfg_t    cfg_reg;
    drg_pkg::desc_t   f_data;
    drg_pkg::desc_t   q_rdata;
    drg_pkg::vertex_t vout;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                drg_pkg::REG_CENTER_MODE:  cfg_reg.center_mode  <= cfg_data[0];
                drg_pkg::REG_ROUND_RADIUS: cfg_reg.round_radius <= cfg_data;
                drg_pkg::REG_DECOR_STYLE:  cfg_reg.decor_style  <= cfg_data[1:0];
                drg_pkg::REG_DECOR_PLACE:  cfg_reg.decor_place  <= cfg_data[1:0];
                drg_pkg::REG_DECOR_EXTENT: cfg_reg.decor_extent <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    drg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (f_data)
    );

    drg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_wdata (f_data),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_rdata (q_rdata)
    );

    drg_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .vout    (vout)
    );

    assign vertex_x    = vout.x;
    assign vertex_y    = vout.y;
    assign is_arc      = vout.arc;
    assign center_x    = vout.cx;
    assign center_y    = vout.cy;
    assign last_vertex = vout.last;

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back popped an empty queue");

    a_arc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_arc) |-> !last_vertex)
        else $error("arc start on final vertex");

    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_arc) |-> (center_x == '0 && center_y == '0))
        else $error("arc center set on a plain vertex");

endmodule
